// ===== rtl/xip_pkg.sv =====
// Shared types and constants of the execute-in-place page cache.
package xip_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;

    // Number of page entries; the page number and page index ports are sized for it.
    localparam int unsigned PAGES = 16;

    typedef enum logic [1:0] {
        CMD_FETCH = 2'd0,
        CMD_PAGE_CFG = 2'd1,
        CMD_REFILL_DONE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT = 3'd0,
        ST_REFILL = 3'd1,
        ST_BUSY = 3'd2,
        ST_NO_AREA = 3'd3,
        ST_NO_PAGE = 3'd4,
        ST_DONE = 3'd5
    } t_status;

    localparam logic [CfgIdxW-1:0] REG_AREA0_ADDR = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AREA1_ADDR = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AREA2_ADDR = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_AREA0_GEOM = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_AREA1_GEOM = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_AREA2_GEOM = 3'd5;

    localparam logic [31:0] LOCAL_REGION = 32'h1c00_0000;
    localparam logic [31:0] LOCAL_OFFSET_MASK = 32'h001f_ffff;
    localparam logic [31:0] TAG_DROP_BIT = 32'h2000_0000;

    // One classified item, passed from the front to the back.
    typedef struct packed {
        t_cmd cmd;
        logic area_ok;
        logic [1:0] area;
        logic [31:0] addr;
        logic [31:0] tag;
        logic [31:0] offset;
        logic [16:0] size;
        logic [31:0] ext_base;
        logic wr;
        logic [4:0] pnum;
        logic [31:0] setting;
    } t_item;

endpackage

// ===== rtl/execute_in_place_page_cache.sv =====
// Top level of the execute-in-place page cache.
// Each item is classified in the front end (window match, tag) as it is pushed,
// waits in a two-entry queue and is executed by the back end against all pages
// at once; results leave through a one-entry output register. Between a push and
// its result lie the queue entry and the output register, and the block sustains one
// item per cycle when pop keeps up. With pop held off, three items fill the
// block and full stays high until the result is popped. The user must write
// configuration only while idle; the block itself does not enforce it.
module execute_in_place_page_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_fetch_address,
    input  logic        i_fetch_write,
    input  logic [3:0]  i_page_number,
    input  logic [31:0] i_page_setting,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [1:0]  o_area_hit,
    output logic [3:0]  o_page_used,
    output logic [31:0] o_local_address,
    output logic [31:0] o_external_address,
    output logic [16:0] o_refill_bytes,
    output logic        o_refill_write
);
    xip_pkg::t_item f_item, q_item;
    logic q_empty, take;

    xip_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd, .i_fetch_address, .i_fetch_write,
        .i_page_number, .i_page_setting, .o_item(f_item)
    );

    xip_queue #(.W($bits(xip_pkg::t_item))) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(f_item), .o_full(full),
        .i_pop(take), .o_empty(q_empty), .o_data(q_item)
    );

    xip_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .i_item(q_item), .o_take(take),
        .o_empty(empty), .i_pop(pop), .o_status, .o_area_hit, .o_page_used,
        .o_local_address, .o_external_address, .o_refill_bytes, .o_refill_write
    );
endmodule

// ===== rtl/xip_front.sv =====
// Front end: window match and tag formation for each accepted item.
module xip_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data,
    input  logic [1:0]      i_cmd,
    input  logic [31:0]     i_fetch_address,
    input  logic            i_fetch_write,
    input  logic [3:0]      i_page_number,
    input  logic [31:0]     i_page_setting,
    output xip_pkg::t_item  o_item
);
    logic [63:0] r_addr [3];
    logic [18:0] r_geom [3];
    logic [2:0] hit;
    logic [16:0] size [3];
    logic [1:0] w;
    logic [16:0] sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_addr[k] <= '0;
                r_geom[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                xip_pkg::REG_AREA0_ADDR: r_addr[0] <= i_cfg_data;
                xip_pkg::REG_AREA1_ADDR: r_addr[1] <= i_cfg_data;
                xip_pkg::REG_AREA2_ADDR: r_addr[2] <= i_cfg_data;
                xip_pkg::REG_AREA0_GEOM: r_geom[0] <= i_cfg_data[18:0];
                xip_pkg::REG_AREA1_GEOM: r_geom[1] <= i_cfg_data[18:0];
                xip_pkg::REG_AREA2_GEOM: r_geom[2] <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] span;
            logic [31:0] last;
            size[k] = 17'd512 << r_geom[k][18:16];
            // Count times size is a shift, so the end needs no multiplier.
            span = {16'd0, r_geom[k][15:0]} << (5'd9 + {2'd0, r_geom[k][18:16]});
            last = r_addr[k][31:0] + span;
            hit[k] = (i_fetch_address >= r_addr[k][31:0]) && (i_fetch_address < last);
        end
        w = hit[0] ? 2'd0 : hit[1] ? 2'd1 : 2'd2;
        sz = size[w];
        o_item.cmd = xip_pkg::t_cmd'(i_cmd);
        o_item.area_ok = |hit;
        o_item.area = w;
        o_item.addr = i_fetch_address;
        o_item.offset = i_fetch_address & ({15'd0, sz} - 32'd1);
        o_item.tag = i_fetch_address & ~(({15'd0, sz} - 32'd1) | xip_pkg::TAG_DROP_BIT);
        o_item.size = sz;
        o_item.ext_base = r_addr[w][63:32];
        o_item.wr = i_fetch_write;
        o_item.pnum = {1'b0, i_page_number};
        o_item.setting = i_page_setting;
    end
endmodule

// ===== rtl/xip_queue.sv =====
// Two-entry queue between the front and back ends.
module xip_queue #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end
endmodule

// ===== rtl/xip_back.sv =====
// Back end: page lookup, victim choice and page table updates.
module xip_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  xip_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [2:0]     o_status,
    output logic [1:0]     o_area_hit,
    output logic [3:0]     o_page_used,
    output logic [31:0]    o_local_address,
    output logic [31:0]    o_external_address,
    output logic [16:0]    o_refill_bytes,
    output logic           o_refill_write
);
    localparam int unsigned PAGES = xip_pkg::PAGES;
    localparam int unsigned PW = $clog2(PAGES);

    logic [PAGES-1:0] r_valid;
    logic [1:0] r_win [PAGES];
    logic [31:0] r_tag [PAGES];
    logic [31:0] r_base [PAGES];
    logic [PAGES-1:0] r_usable [4];
    logic [PW-1:0] r_vptr;
    logic r_pending;
    logic r_full;

    logic [PAGES-1:0] match, avail, rot;
    logic hit;
    logic [PW-1:0] hidx, vidx, roff;

    assign o_take = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;

    always_comb begin
        hit = 1'b0;
        hidx = '0;
        for (int k = PAGES - 1; k >= 0; k--) begin
            match[k] = r_valid[k] && (r_win[k] == i_item.area) && (r_tag[k] == i_item.tag);
            if (match[k]) begin
                hit = 1'b1;
                hidx = PW'(k);
            end
        end
        avail = r_usable[i_item.area];
        // Rotate so the round-robin pointer sits at bit 0, then take the first set bit.
        for (int k = 0; k < PAGES; k++)
            rot[k] = avail[(k + int'(r_vptr)) % PAGES];
        roff = '0;
        for (int k = PAGES - 1; k >= 0; k--)
            if (rot[k]) roff = PW'(k);
        vidx = PW'(({1'b0, r_vptr} + {1'b0, roff}) % (PW + 1)'(PAGES));
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            o_status <= xip_pkg::ST_DONE;
            o_area_hit <= '0;
            o_page_used <= '0;
            o_local_address <= '0;
            o_external_address <= '0;
            o_refill_bytes <= '0;
            o_refill_write <= 1'b0;
            if (i_item.cmd == xip_pkg::CMD_FETCH) begin
                if (!i_item.area_ok) begin
                    o_status <= xip_pkg::ST_NO_AREA;
                end else begin
                    o_area_hit <= i_item.area;
                    if (r_pending) begin
                        o_status <= xip_pkg::ST_BUSY;
                    end else if (hit) begin
                        o_status <= xip_pkg::ST_HIT;
                        o_page_used <= 4'(hidx);
                        o_local_address <= r_base[hidx] + i_item.offset;
                    end else if (avail == '0) begin
                        o_status <= xip_pkg::ST_NO_PAGE;
                    end else begin
                        o_status <= xip_pkg::ST_REFILL;
                        o_page_used <= 4'(vidx);
                        o_local_address <= r_base[vidx];
                        o_external_address <= i_item.tag + i_item.ext_base;
                        o_refill_bytes <= i_item.size;
                        o_refill_write <= i_item.wr;
                    end
                end
            end
        end
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_valid <= '0;
            r_pending <= 1'b0;
            r_vptr <= '0;
            for (int k = 0; k < 4; k++) r_usable[k] <= '0;
            for (int k = 0; k < PAGES; k++) begin
                r_win[k] <= '0;
                r_tag[k] <= '0;
                r_base[k] <= '0;
            end
        end else begin
            if (o_take) r_full <= 1'b1;
            else if (i_pop) r_full <= 1'b0;
            if (o_take) begin
                case (i_item.cmd)
                    xip_pkg::CMD_FETCH: begin
                        if (i_item.area_ok && !r_pending && !hit && avail != '0) begin
                            r_valid[vidx] <= 1'b1;
                            r_win[vidx] <= i_item.area;
                            r_tag[vidx] <= i_item.tag;
                            r_pending <= 1'b1;
                            r_vptr <= PW'(({1'b0, vidx} + 1'b1) % (PW + 1)'(PAGES));
                        end
                    end
                    xip_pkg::CMD_PAGE_CFG: begin
                        if (i_item.pnum < 5'(PAGES)) begin
                            r_valid[PW'(i_item.pnum)] <= 1'b0;
                            r_win[PW'(i_item.pnum)] <= i_item.setting[31:30];
                            r_base[PW'(i_item.pnum)] <= xip_pkg::LOCAL_REGION
                                | (i_item.setting & xip_pkg::LOCAL_OFFSET_MASK);
                            r_usable[i_item.setting[31:30]][PW'(i_item.pnum)] <= 1'b1;
                        end
                    end
                    xip_pkg::CMD_REFILL_DONE: r_pending <= 1'b0;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/xip_checker.sv =====
// Port-level checks of the execute-in-place page cache.
module xip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic [16:0] o_refill_bytes
);
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= xip_pkg::ST_DONE)) else $error("bad status");
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == xip_pkg::ST_REFILL) |-> (o_refill_bytes >= 17'd512))
        else $error("bad refill length");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != xip_pkg::ST_REFILL) |-> (o_refill_bytes == 17'd0))
        else $error("length without refill");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status))) else $error("result lost");
endmodule

bind execute_in_place_page_cache xip_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_status, .o_refill_bytes
);

// ===== sim/execute_in_place_page_cache_tb.sv =====
// Self-checking testbench for the execute-in-place page cache.
`timescale 1ns / 100ps

module execute_in_place_page_cache_tb;

    typedef struct {
        xip_pkg::t_status status;
        logic [1:0]  area;
        logic [3:0]  page;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [16:0] bytes;
        logic        wr;
    } t_answer;

    // Cache model plus the queue of answers that are still owed by the block.
    class xip_scoreboard;
        logic [63:0] area_addr [3];
        logic [18:0] area_geom [3];
        bit          pg_valid [16];
        logic [1:0]  pg_win [16];
        logic [31:0] pg_tag [16];
        logic [31:0] pg_base [16];
        logic [15:0] usable [4];
        logic [3:0]  victim_ptr;
        bit          pending;
        t_answer     owed [$];
        int          errors;
        int          checked;
        int          status_seen [6];

        function new();
            for (int i = 0; i < 3; i++) begin
                area_addr[i] = '0;
                area_geom[i] = '0;
            end
            for (int i = 0; i < 16; i++) begin
                pg_valid[i] = 0;
                pg_win[i] = '0;
                pg_tag[i] = '0;
                pg_base[i] = '0;
            end
            for (int i = 0; i < 4; i++) usable[i] = '0;
            victim_ptr = '0;
            pending = 0;
            errors = 0;
            checked = 0;
            for (int i = 0; i < 6; i++) status_seen[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            if (idx <= xip_pkg::REG_AREA2_ADDR) area_addr[idx] = data;
            else if (idx <= xip_pkg::REG_AREA2_GEOM) area_geom[idx - 3'd3] = data[18:0];
        endfunction

        function logic [31:0] page_bytes(int w);
            return 32'd512 << area_geom[w][18:16];
        endfunction

        function void note_item(xip_pkg::t_cmd cmd, logic [31:0] addr, logic wr,
                                logic [3:0] pnum, logic [31:0] setting);
            t_answer a;
            int w;
            int hit;
            logic [31:0] sz, tag, fin;
            logic [15:0] avail;
            int v;
            a = '{xip_pkg::ST_DONE, 2'd0, 4'd0, 32'd0, 32'd0, 17'd0, 1'b0};
            if (cmd == xip_pkg::CMD_FETCH) begin
                w = -1;
                for (int i = 0; i < 3 && w < 0; i++) begin
                    fin = area_addr[i][31:0] + area_geom[i][15:0] * page_bytes(i);
                    if (addr >= area_addr[i][31:0] && addr < fin) w = i;
                end
                if (w < 0) begin
                    a.status = xip_pkg::ST_NO_AREA;
                end else begin
                    sz = page_bytes(w);
                    tag = addr & ~((sz - 1) | xip_pkg::TAG_DROP_BIT);
                    hit = -1;
                    for (int i = 0; i < 16 && hit < 0; i++)
                        if (pg_valid[i] && pg_win[i] == w && pg_tag[i] == tag) hit = i;
                    a.area = 2'(w);
                    if (pending) begin
                        a.status = xip_pkg::ST_BUSY;
                    end else if (hit >= 0) begin
                        a.status = xip_pkg::ST_HIT;
                        a.page = 4'(hit);
                        a.local_addr = pg_base[hit] + (addr & (sz - 1));
                    end else begin
                        avail = usable[w];
                        if (avail == 0) begin
                            a.status = xip_pkg::ST_NO_PAGE;
                        end else begin
                            v = int'(victim_ptr);
                            while (!avail[v]) v = (v + 1) % 16;
                            victim_ptr = 4'((v + 1) % 16);
                            pending = 1;
                            pg_win[v] = 2'(w);
                            pg_tag[v] = tag;
                            pg_valid[v] = 1;
                            a.status = xip_pkg::ST_REFILL;
                            a.page = 4'(v);
                            a.local_addr = pg_base[v];
                            a.remote_addr = tag + area_addr[w][63:32];
                            a.bytes = sz[16:0];
                            a.wr = wr;
                        end
                    end
                end
            end else if (cmd == xip_pkg::CMD_PAGE_CFG) begin
                pg_win[pnum] = setting[31:30];
                pg_base[pnum] = xip_pkg::LOCAL_REGION | (setting & xip_pkg::LOCAL_OFFSET_MASK);
                pg_valid[pnum] = 0;
                usable[setting[31:30]][pnum] = 1'b1;
            end else if (cmd == xip_pkg::CMD_REFILL_DONE) begin
                pending = 0;
            end
            owed = {owed, a};
        endfunction

        function void check_answer(t_answer got);
            t_answer e;
            checked++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected transaction, status %0d", $time, got.status);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (e.status <= xip_pkg::ST_DONE) status_seen[e.status]++;
            if (got.status !== e.status || got.area !== e.area || got.page !== e.page
                || got.local_addr !== e.local_addr || got.remote_addr !== e.remote_addr
                || got.bytes !== e.bytes || got.wr !== e.wr) begin
                $display("%0t: mismatch expected st=%0d area=%0d pg=%0d loc=%h ext=%h n=%0d w=%b",
                         $time, e.status, e.area, e.page, e.local_addr, e.remote_addr,
                         e.bytes, e.wr);
                $display("%0t:          actual   st=%0d area=%0d pg=%0d loc=%h ext=%h n=%0d w=%b",
                         $time, got.status, got.area, got.page, got.local_addr,
                         got.remote_addr, got.bytes, got.wr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [1:0]  i_cmd;
    logic [31:0] i_fetch_address;
    logic        i_fetch_write;
    logic [3:0]  i_page_number;
    logic [31:0] i_page_setting;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [1:0]  o_area_hit;
    logic [3:0]  o_page_used;
    logic [31:0] o_local_address;
    logic [31:0] o_external_address;
    logic [16:0] o_refill_bytes;
    logic        o_refill_write;

    execute_in_place_page_cache dut (.*);

    xip_scoreboard cache_sb;
    bit calm;          // no idling on either side
    bit hold_results;  // long receiver hold-off
    logic [31:0] win_lo [3];
    logic [31:0] win_span [3];

    initial begin
        i_clk = 0;
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        cache_sb.write_reg(idx, data);
    endtask

    // Sets one window and remembers its span so fetches can be aimed inside.
    task automatic set_window(int w, logic [31:0] start, logic [31:0] ext,
                              logic [15:0] count, logic [2:0] code);
        write_cfg(3'(xip_pkg::REG_AREA0_ADDR + w), {ext, start});
        write_cfg(3'(xip_pkg::REG_AREA0_GEOM + w), 64'({code, count}));
        win_lo[w] = start;
        win_span[w] = count * (32'd512 << code);
    endtask

    // Push stays high after acceptance, so back-to-back items need no gap;
    // drain() lowers it when the sender stops.
    task automatic send_item(xip_pkg::t_cmd cmd, logic [31:0] addr, logic wr,
                             logic [3:0] pnum, logic [31:0] setting);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            push <= 0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1;
        i_cmd <= cmd;
        i_fetch_address <= addr;
        i_fetch_write <= wr;
        i_page_number <= pnum;
        i_page_setting <= setting;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        cache_sb.note_item(cmd, addr, wr, pnum, setting);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        push <= 0;
        while (cache_sb.owed.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (6) @(negedge i_clk);
    endtask

    // Mostly fetches aimed into configured windows, with refill done replies.
    task automatic random_fetch();
        int w;
        logic [31:0] a;
        w = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) a = $urandom;
        else if (win_span[w] == 0) a = win_lo[w];
        else a = win_lo[w] + ($urandom % win_span[w]);
        if ($urandom_range(0, 7) == 0) a = a ^ xip_pkg::TAG_DROP_BIT;
        send_item(xip_pkg::CMD_FETCH, a, 1'($urandom_range(0, 1)), 4'($urandom), $urandom);
        if (cache_sb.pending && $urandom_range(0, 3) != 0)
            send_item(xip_pkg::CMD_REFILL_DONE, $urandom, 1'($urandom_range(0, 1)),
                      4'($urandom), $urandom);
    endtask

    task automatic page_cfg(logic [3:0] p, logic [1:0] w);
        send_item(xip_pkg::CMD_PAGE_CFG, $urandom, 1'($urandom_range(0, 1)), p,
                  {w, 9'($urandom), 21'($urandom)});
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        if (i_rst_n && pop && !empty) begin
            got.status = xip_pkg::t_status'(o_status);
            got.area = o_area_hit;
            got.page = o_page_used;
            got.local_addr = o_local_address;
            got.remote_addr = o_external_address;
            got.bytes = o_refill_bytes;
            got.wr = o_refill_write;
            cache_sb.check_answer(got);
        end
    end

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        pop = 0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                pop <= 0;
                for (n = 0; n < 200; n++) @(negedge i_clk);
                hold_results = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                pop <= 1;
            end
        end
    end

    initial begin
        #5000000;
        $display("FAIL execute_in_place_page_cache");
        $finish;
    end

    initial begin
        int phase;
        cache_sb = new();
        calm = 0;
        hold_results = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        push = 0;
        i_cmd = xip_pkg::CMD_FETCH;
        i_fetch_address = '0;
        i_fetch_write = 0;
        i_page_number = '0;
        i_page_setting = '0;
        for (int i = 0; i < 3; i++) begin
            win_lo[i] = 0;
            win_span[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: nothing configured, then windows and extreme fields.
        send_item(xip_pkg::CMD_FETCH, 32'h0, 0, 4'h0, 32'h0);
        send_item(xip_pkg::CMD_UNUSED, 32'hffff_ffff, 1, 4'hf, 32'hffff_ffff);
        send_item(xip_pkg::CMD_REFILL_DONE, 32'h0, 0, 4'h0, 32'h0);
        drain();
        set_window(0, 32'h1000_0000, 32'h8000_0000, 16'd4, 3'd0);
        set_window(1, 32'h3000_0000, 32'hffff_ffff, 16'd2, 3'd7);
        set_window(2, 32'hffff_0000, 32'h0000_1000, 16'hffff, 3'd7);
        send_item(xip_pkg::CMD_FETCH, 32'h1000_0010, 1, 4'h0, 32'h0);   // window but no page
        page_cfg(4'd0, 2'd0);
        page_cfg(4'd15, 2'd1);
        send_item(xip_pkg::CMD_PAGE_CFG, 32'h0, 0, 4'd7, 32'hffff_ffff); // window 3, never used
        send_item(xip_pkg::CMD_FETCH, 32'h1000_0010, 1, 4'h0, 32'h0);   // refill
        send_item(xip_pkg::CMD_FETCH, 32'h1000_0010, 0, 4'h0, 32'h0);   // busy
        send_item(xip_pkg::CMD_REFILL_DONE, 32'h0, 0, 4'h0, 32'h0);
        send_item(xip_pkg::CMD_FETCH, 32'h1000_01ff, 0, 4'h0, 32'h0);   // hit
        send_item(xip_pkg::CMD_FETCH, 32'h1000_0800, 0, 4'h0, 32'h0);   // past end
        send_item(xip_pkg::CMD_FETCH, 32'h3001_ffff, 1, 4'h0, 32'h0);   // 64 KiB page
        send_item(xip_pkg::CMD_REFILL_DONE, 32'h0, 0, 4'h0, 32'h0);
        send_item(xip_pkg::CMD_FETCH, 32'h0fff_ffff, 0, 4'h0, 32'h0);   // just below start
        send_item(xip_pkg::CMD_FETCH, 32'hffff_ffff, 0, 4'h0, 32'h0);   // wrapped end
        page_cfg(4'd0, 2'd2);                                          // reassign, keeps old bit
        send_item(xip_pkg::CMD_FETCH, 32'h1000_0010, 0, 4'h0, 32'h0);
        send_item(xip_pkg::CMD_REFILL_DONE, 32'h0, 0, 4'h0, 32'h0);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_window(0, 32'h0000_0000, 32'h1234_5678, 16'd40, 3'd0);
                    set_window(1, 32'h2000_4000, 32'h0, 16'd20, 3'd2);
                    set_window(2, 32'hc000_0000, 32'hf000_0000, 16'd8, 3'd4);
                end
                1: begin
                    set_window(0, $urandom, $urandom, 16'($urandom_range(1, 64)), 3'($urandom));
                    set_window(1, $urandom, $urandom, 16'($urandom_range(1, 64)), 3'($urandom));
                    set_window(2, $urandom, $urandom, 16'hffff, 3'd7);
                end
                2: begin
                    set_window(0, 32'hffff_ffff, 32'hffff_ffff, 16'd0, 3'd7);
                    set_window(1, 32'h1fff_f000, 32'h0, 16'd64, 3'd1);
                    set_window(2, $urandom, $urandom, 16'($urandom_range(1, 30)), 3'($urandom));
                end
                default: begin
                    set_window(0, 32'h0, 32'h0, 16'd16, 3'd3);
                    set_window(1, 32'h4000_0000, 32'hdead_0000, 16'd64, 3'd0);
                    set_window(2, $urandom, $urandom, 16'($urandom_range(1, 30)), 3'($urandom));
                end
            endcase
            for (int p = 0; p < 16; p++)
                if ($urandom_range(0, 3) != 0) page_cfg(4'(p), 2'($urandom_range(0, 2)));
            if (phase == 1) hold_results = 1;
            calm = (phase == 3);
            for (int k = 0; k < 280; k++) begin
                case ($urandom_range(0, 19))
                    0: page_cfg(4'($urandom), 2'($urandom));
                    1: send_item(xip_pkg::t_cmd'($urandom_range(2, 3)), $urandom,
                                 1'($urandom_range(0, 1)), 4'($urandom), $urandom);
                    default: random_fetch();
                endcase
            end
            send_item(xip_pkg::CMD_REFILL_DONE, 32'h0, 0, 4'h0, 32'h0);
            drain();
        end

        $display("Checked %0d transactions over four window settings: hit %0d, refill %0d,",
                 cache_sb.checked, cache_sb.status_seen[xip_pkg::ST_HIT],
                 cache_sb.status_seen[xip_pkg::ST_REFILL]);
        $display("busy %0d, no_area %0d, no_page %0d, done %0d.",
                 cache_sb.status_seen[xip_pkg::ST_BUSY],
                 cache_sb.status_seen[xip_pkg::ST_NO_AREA],
                 cache_sb.status_seen[xip_pkg::ST_NO_PAGE],
                 cache_sb.status_seen[xip_pkg::ST_DONE]);
        if (cache_sb.errors == 0 && cache_sb.owed.size() == 0) begin
            $display("PASS execute_in_place_page_cache");
        end else begin
            $display("FAIL execute_in_place_page_cache");
        end
        $finish;
    end
endmodule
